/* src/assert_macros.svh */
// Assertion macros shared by the frame receiver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds at the next edge after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dfr_pkg.sv */
package dfr_pkg;

    localparam int CHANNELS_DEF  = 4;
    localparam int BUF_BYTES_DEF = 64;

    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_BANG   = 8'h21;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = 1;
    localparam int Q_CW    = 2;

    typedef enum logic [1:0] {
        K_IGNORE,
        K_BYTE,
        K_HOLD,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  ch;
        logic [7:0]  data;
        logic [6:0]  limit;
    } t_cmd;

    typedef enum logic {
        BS_IDLE,
        BS_READ
    } t_bstate;

endpackage

/* src/delimited_frame_receiver_unit.sv */
// Byte beats: a beat goes from the command queue into the output register; one beat per
// cycle while the output is not stalled. Read beats: bytes go from the single frame memory
// read port via a read data register to the output, one byte per cycle unless it stalls;
// a read holds the back end. A two-entry command queue lets input and output stall apart.
// Reset (synchronous, active low) clears the queue, the output and all channel flags
// and lengths at once; the frame memory is not cleared and needs no clearing pass.
module delimited_frame_receiver_unit #(
    parameter int CHANNELS  = dfr_pkg::CHANNELS_DEF,
    parameter int BUF_BYTES = dfr_pkg::BUF_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_func,
    input  logic [1:0] i_channel,
    input  logic [7:0] i_data,
    input  logic [6:0] i_read_limit,
    output logic       empty,
    input  logic       pop,
    output logic       o_ready_flag,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_last
);

    logic          q_vld;
    logic          q_pop;
    dfr_pkg::t_cmd q_cmd;

    dfr_front #(
        .CHANNELS(CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_func      (i_func),
        .i_channel   (i_channel),
        .i_data      (i_data),
        .i_read_limit(i_read_limit),
        .o_q_vld     (q_vld),
        .o_q_cmd     (q_cmd),
        .i_q_pop     (q_pop)
    );

    dfr_back #(
        .CHANNELS (CHANNELS),
        .BUF_BYTES(BUF_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (q_vld),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .pop         (pop),
        .empty       (empty),
        .o_ready_flag(o_ready_flag),
        .o_out_byte  (o_out_byte),
        .o_byte_valid(o_byte_valid),
        .o_last      (o_last)
    );

endmodule

/* src/dfr_front.sv */
`include "assert_macros.svh"

module dfr_front #(
    parameter int CHANNELS = dfr_pkg::CHANNELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic          i_func,
    input  logic [1:0]    i_channel,
    input  logic [7:0]    i_data,
    input  logic [6:0]    i_read_limit,
    output logic          o_q_vld,
    output dfr_pkg::t_cmd o_q_cmd,
    input  logic          i_q_pop
);

    dfr_pkg::t_cmd r_q [dfr_pkg::Q_DEPTH];
    logic [dfr_pkg::Q_PW-1:0] r_wp, r_rp;
    logic [dfr_pkg::Q_CW-1:0] r_cnt, n_cnt;
    dfr_pkg::t_cmd in_cmd;
    logic          ch_ok;
    logic          push_acc;

    assign ch_ok    = (int'(i_channel) < CHANNELS);
    assign full     = (r_cnt == dfr_pkg::Q_CW'(dfr_pkg::Q_DEPTH));
    assign push_acc = push && !full;
    assign o_q_vld  = (r_cnt != '0);
    assign o_q_cmd  = r_q[r_rp];

    always_comb begin
        in_cmd.ch    = i_channel;
        in_cmd.data  = i_data;
        in_cmd.limit = i_read_limit;
        priority if (!ch_ok) begin
            in_cmd.kind = dfr_pkg::K_IGNORE;
        end else if (!i_func) begin
            in_cmd.kind = dfr_pkg::K_BYTE;
        end else if (i_read_limit == '0) begin
            in_cmd.kind = dfr_pkg::K_HOLD;
        end else begin
            in_cmd.kind = dfr_pkg::K_READ;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push_acc && !i_q_pop) begin
            n_cnt = r_cnt + dfr_pkg::Q_CW'(1);
        end else if (!push_acc && i_q_pop) begin
            n_cnt = r_cnt - dfr_pkg::Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push_acc) begin
                r_wp <= r_wp + dfr_pkg::Q_PW'(1);
            end
            if (i_q_pop) begin
                r_rp <= r_rp + dfr_pkg::Q_PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_acc) begin
            r_q[r_wp] <= in_cmd;
        end
    end

    `ASSERT_ALWAYS(a_cnt_range, r_cnt <= dfr_pkg::Q_CW'(dfr_pkg::Q_DEPTH), "queue overfilled")
    `ASSERT_IMPLY(a_pop_nonempty, i_q_pop, r_cnt != '0, "pop from empty queue")
    `ASSERT_NEXT(a_cnt_rise, push_acc && !i_q_pop, r_cnt == $past(r_cnt) + 2'd1, "count lost")

endmodule

/* src/dfr_back.sv */
`include "assert_macros.svh"

module dfr_back #(
    parameter int CHANNELS  = dfr_pkg::CHANNELS_DEF,
    parameter int BUF_BYTES = dfr_pkg::BUF_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_vld,
    input  dfr_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    input  logic          pop,
    output logic          empty,
    output logic          o_ready_flag,
    output logic [7:0]    o_out_byte,
    output logic          o_byte_valid,
    output logic          o_last
);

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FW        = $clog2(BUF_BYTES);
    localparam int MEM_DEPTH = CHANNELS * BUF_BYTES;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [FW:0]   BUF_LIM = (FW + 1)'(BUF_BYTES - 1);
    localparam logic [AW-1:0] BUF_A   = AW'(BUF_BYTES);

    logic [7:0] r_mem [MEM_DEPTH];

    dfr_pkg::t_bstate r_state, n_state;
    logic [CHANNELS-1:0] r_cap, n_cap;
    logic [CHANNELS-1:0] r_rdy, n_rdy;
    logic [FW-1:0] r_fill [CHANNELS];
    logic [FW-1:0] n_fill [CHANNELS];
    logic [FW-1:0] r_tl [CHANNELS];
    logic [FW-1:0] n_tl [CHANNELS];
    logic [CH_W-1:0] r_ch, n_ch;
    logic [FW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FW-1:0] r_rd_n, n_rd_n;
    logic r_rd_vld, n_rd_vld;
    logic r_rd_last, n_rd_last;
    logic [7:0] r_rd_data;
    logic r_out_vld, n_out_vld;
    logic r_out_rdy, n_out_rdy;
    logic [7:0] r_out_byte, n_out_byte;
    logic r_out_bv, n_out_bv;
    logic r_out_last, n_out_last;

    logic          out_free;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [CH_W-1:0] cmd_ch;
    logic [AW-1:0] cmd_base, rd_base;
    logic          start;
    logic          b_cap;
    logic [FW:0]   b_fill, b_tl;
    logic [6:0]    lim_m1;
    logic [FW-1:0] rd_n;

    assign out_free  = !r_out_vld || pop;
    assign cmd_ch    = CH_W'(i_q_cmd.ch);
    assign cmd_base  = AW'(cmd_ch) * BUF_A;
    assign rd_base   = AW'(r_ch) * BUF_A;
    assign mem_raddr = rd_base + AW'(r_rd_ptr);

    always_comb begin
        n_state    = r_state;
        n_cap      = r_cap;
        n_rdy      = r_rdy;
        n_fill     = r_fill;
        n_tl       = r_tl;
        n_ch       = r_ch;
        n_rd_ptr   = r_rd_ptr;
        n_rd_n     = r_rd_n;
        n_rd_vld   = r_rd_vld;
        n_rd_last  = r_rd_last;
        n_out_vld  = r_out_vld && !pop;
        n_out_rdy  = r_out_rdy;
        n_out_byte = r_out_byte;
        n_out_bv   = r_out_bv;
        n_out_last = r_out_last;
        o_q_pop    = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = cmd_base;
        start      = (i_q_cmd.data == dfr_pkg::CHAR_HASH) ||
                     (i_q_cmd.data == dfr_pkg::CHAR_DOLLAR);
        b_cap      = r_cap[cmd_ch] | start;
        b_fill     = start ? '0 : {1'b0, r_fill[cmd_ch]};
        b_tl       = start ? '0 : {1'b0, r_tl[cmd_ch]};
        lim_m1     = i_q_cmd.limit - 7'd1;
        rd_n       = (7'(r_tl[cmd_ch]) < lim_m1) ? r_tl[cmd_ch] : FW'(lim_m1);

        unique case (r_state)
            dfr_pkg::BS_IDLE: begin
                if (i_q_vld && out_free) begin
                    o_q_pop    = 1'b1;
                    n_out_vld  = 1'b1;
                    n_out_rdy  = 1'b0;
                    n_out_byte = '0;
                    n_out_bv   = 1'b0;
                    n_out_last = 1'b1;
                    unique case (i_q_cmd.kind)
                        dfr_pkg::K_IGNORE: begin
                        end
                        dfr_pkg::K_HOLD: begin
                            n_out_rdy = r_rdy[cmd_ch];
                        end
                        dfr_pkg::K_BYTE: begin
                            if (!r_rdy[cmd_ch] && b_cap) begin
                                if (b_fill >= BUF_LIM) begin
                                    n_cap[cmd_ch]  = 1'b0;
                                    n_rdy[cmd_ch]  = 1'b0;
                                    n_fill[cmd_ch] = '0;
                                    n_tl[cmd_ch]   = '0;
                                end else begin
                                    mem_we    = 1'b1;
                                    mem_waddr = cmd_base + AW'(b_fill);
                                    if (b_tl == b_fill && i_q_cmd.data != dfr_pkg::CHAR_NUL) begin
                                        b_tl = b_fill + (FW + 1)'(1);
                                    end
                                    b_fill = b_fill + (FW + 1)'(1);
                                    if (b_fill >= BUF_LIM) begin
                                        n_cap[cmd_ch]  = 1'b0;
                                        n_rdy[cmd_ch]  = 1'b0;
                                        n_fill[cmd_ch] = '0;
                                        n_tl[cmd_ch]   = '0;
                                    end else begin
                                        n_fill[cmd_ch] = FW'(b_fill);
                                        n_tl[cmd_ch]   = FW'(b_tl);
                                        n_cap[cmd_ch]  = 1'b1;
                                        if (i_q_cmd.data == dfr_pkg::CHAR_BANG) begin
                                            n_rdy[cmd_ch] = 1'b1;
                                            n_cap[cmd_ch] = 1'b0;
                                        end
                                    end
                                end
                            end
                            n_out_rdy = n_rdy[cmd_ch];
                        end
                        dfr_pkg::K_READ: begin
                            n_cap[cmd_ch]  = 1'b0;
                            n_rdy[cmd_ch]  = 1'b0;
                            n_fill[cmd_ch] = '0;
                            n_tl[cmd_ch]   = '0;
                            if (rd_n != '0) begin
                                n_out_vld = 1'b0;
                                n_state   = dfr_pkg::BS_READ;
                                n_ch      = cmd_ch;
                                n_rd_ptr  = '0;
                                n_rd_n    = rd_n;
                            end
                        end
                    endcase
                end
            end
            dfr_pkg::BS_READ: begin
                if (r_rd_vld && out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_rdy  = 1'b0;
                    n_out_byte = r_rd_data;
                    n_out_bv   = 1'b1;
                    n_out_last = r_rd_last;
                    n_rd_vld   = 1'b0;
                end
                if (r_rd_ptr != r_rd_n && (!r_rd_vld || out_free)) begin
                    mem_re    = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_last = (r_rd_ptr + FW'(1) == r_rd_n);
                    n_rd_ptr  = r_rd_ptr + FW'(1);
                end
                if (r_rd_ptr == r_rd_n && !r_rd_vld) begin
                    n_state = dfr_pkg::BS_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dfr_pkg::BS_IDLE;
            r_cap     <= '0;
            r_rdy     <= '0;
            r_fill    <= '{default: '0};
            r_tl      <= '{default: '0};
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cap     <= n_cap;
            r_rdy     <= n_rdy;
            r_fill    <= n_fill;
            r_tl      <= n_tl;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch       <= n_ch;
        r_rd_ptr   <= n_rd_ptr;
        r_rd_n     <= n_rd_n;
        r_rd_last  <= n_rd_last;
        r_out_rdy  <= n_out_rdy;
        r_out_byte <= n_out_byte;
        r_out_bv   <= n_out_bv;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_q_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    assign empty        = !r_out_vld;
    assign o_ready_flag = r_out_rdy;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_out_bv;
    assign o_last       = r_out_last;

    `ASSERT_ALWAYS(a_rdy_cap_excl, (r_rdy & r_cap) == '0, "channel both ready and capturing")
    `ASSERT_IMPLY(a_ptr_bound, r_state == dfr_pkg::BS_READ, r_rd_ptr <= r_rd_n, "read overrun")
    `ASSERT_IMPLY(a_no_pop_in_read, r_state == dfr_pkg::BS_READ, !o_q_pop, "pop during read")
    `ASSERT_IMPLY(a_rd_in_read, r_rd_vld, r_state == dfr_pkg::BS_READ, "stray read data")

endmodule
